[rtl/core/spc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Constants, codes and helper functions for the sprite pixel collision block.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int SHEET_WIDTH   = 128;
    localparam int SHEET_HEIGHT  = 128;
    localparam int MAX_CELL_SIZE = 64;
    localparam int WORD_BITS     = 32;
    localparam int WORD_SHIFT    = $clog2(WORD_BITS);
    localparam int WORDS_PER_ROW = SHEET_WIDTH / WORD_BITS;
    localparam int MASK_DEPTH    = 512;
    localparam int ADDR_W        = $clog2(MASK_DEPTH);
    localparam int COORD_W       = 24;
    localparam int SIZE_W        = 7;
    localparam int CPR_W         = 8;
    localparam int CELL_W        = 14;
    localparam int POS_W         = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT_A   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_ROW_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH_B    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT_B   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_ROW_B = 3'd5;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic SHEET_A   = 1'b0;

    localparam logic [1:0] VERDICT_DISJOINT = 2'd0;
    localparam logic [1:0] VERDICT_CLEAR    = 2'd1;
    localparam logic [1:0] VERDICT_HIT      = 2'd2;

    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] s);
        return (int'(s) > MAX_CELL_SIZE) ? SIZE_W'(MAX_CELL_SIZE) : s;
    endfunction

    function automatic logic [CPR_W-1:0] eff_cpr(logic [CPR_W-1:0] c);
        return (c == '0) ? CPR_W'(1) : c;
    endfunction

    // bits below n set, n in 0..WORD_BITS
    function automatic logic [WORD_BITS-1:0] thermo(int n);
        logic [WORD_BITS:0] t;
        t = ((WORD_BITS+1)'(1) << n) - (WORD_BITS+1)'(1);
        return t[WORD_BITS-1:0];
    endfunction

    // valid pixels of one chunk starting at sheet column p on sheet row py
    function automatic logic [WORD_BITS-1:0] chunk_mask(coord_t p, coord_t py,
                                                        logic [SIZE_W-1:0] left);
        int lo;
        int hi;
        int d;
        lo = 0;
        if (p < 0)
        begin
            lo = (int'(p) < -WORD_BITS) ? WORD_BITS : -int'(p);
        end
        hi = WORD_BITS;
        if (int'(left) < hi)
        begin
            hi = int'(left);
        end
        d = SHEET_WIDTH - int'(p);
        if (d < hi)
        begin
            hi = (d < 0) ? 0 : d;
        end
        if (py < 0 || py >= coord_t'(SHEET_HEIGHT) || lo >= hi)
        begin
            return '0;
        end
        return thermo(hi) & ~thermo(lo);
    endfunction

    function automatic logic [ADDR_W-1:0] word_index(coord_t p, coord_t py, int off);
        coord_t col;
        coord_t s;
        col = (p >>> WORD_SHIFT) + coord_t'(off);
        s = py * coord_t'(WORDS_PER_ROW) + col;
        return s[ADDR_W-1:0];
    endfunction

endpackage

[rtl/core/sprite_pixel_collision.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_collision
// Two opacity-mask stores and a query engine that tests two sprite cells for
// a common opaque pixel.
// ----------------------------------------------------------------------------
// Load request: writes one mask word, no result.
// Query: a disjoint result comes from S_RECT; otherwise S_DIV, S_MUL and S_SETUP
// lead to a scan of rows * chunks, chunks = 1 or 2 (32 overlap columns per cycle).
// Rate set by the 14-step cell divider and one mask chunk per cycle, read
// through two ports per store. One query in flight; the receiver cannot stall.
// Reset sets control and config defaults; masks are undefined until loaded.
module sprite_pixel_collision
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               req_type,
    input  logic                               sheet_sel,
    input  logic [spc_pkg::ADDR_W-1:0]         word_addr,
    input  logic [spc_pkg::WORD_BITS-1:0]      mask_word,
    input  logic [spc_pkg::CELL_W-1:0]         cell_a,
    input  logic signed [spc_pkg::POS_W-1:0]   pos_x_a,
    input  logic signed [spc_pkg::POS_W-1:0]   pos_y_a,
    input  logic [spc_pkg::CELL_W-1:0]         cell_b,
    input  logic signed [spc_pkg::POS_W-1:0]   pos_x_b,
    input  logic signed [spc_pkg::POS_W-1:0]   pos_y_b,
    output logic                               done,
    output logic [1:0]                         verdict,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [spc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_RECT, S_DIV, S_MUL, S_SETUP, S_SCAN, S_DRAIN
    } state_t;

    localparam int SW = spc_pkg::SIZE_W;
    localparam int CW = spc_pkg::CELL_W;
    localparam int PW = spc_pkg::POS_W;
    localparam int XW = PW + 1;
    localparam int WB = spc_pkg::WORD_BITS;
    localparam int AW = spc_pkg::ADDR_W;
    localparam int KW = spc_pkg::CPR_W;

    state_t                     state_reg;
    logic                       done_reg;
    logic [1:0]                 verdict_reg;
    logic [3:0]                 div_cnt_reg;
    logic                       pipe_valid_reg;
    logic                       hit_reg;

    logic [SW-1:0]              cw_a_reg, ch_a_reg, cw_b_reg, ch_b_reg;
    logic [KW-1:0]              cpr_a_reg, cpr_b_reg;

    logic signed [PW-1:0]       xa_reg, ya_reg, xb_reg, yb_reg;
    logic signed [XW-1:0]       x0_reg, y0_reg;
    logic [SW-1:0]              span_w_reg, span_h_reg;
    logic [SW-1:0]              wa_reg, ha_reg, wb_reg, hb_reg;
    logic [KW-1:0]              da_reg, db_reg;
    logic [CW-1:0]              qa_reg, qb_reg;
    logic [KW-1:0]              ra_reg, rb_reg;
    spc_pkg::coord_t            ox_a_reg, oy_a_reg, ox_b_reg, oy_b_reg;
    spc_pkg::coord_t            row_px_a_reg, row_px_b_reg;
    spc_pkg::coord_t            px_a_reg, py_a_reg, px_b_reg, py_b_reg;
    logic [SW-1:0]              col_left_reg, rows_left_reg;
    logic [4:0]                 sh_a_reg, sh_b_reg;
    logic [WB-1:0]              mk_a_reg, mk_b_reg;

    logic [WB-1:0]              mask_a_mem [spc_pkg::MASK_DEPTH];
    logic [WB-1:0]              mask_b_mem [spc_pkg::MASK_DEPTH];
    logic [WB-1:0]              rd_a_lo_reg, rd_a_hi_reg, rd_b_lo_reg, rd_b_hi_reg;

    logic                       accept;
    logic signed [XW-1:0]       xa_e, ya_e, xb_e, yb_e;
    logic signed [XW-1:0]       x0_next, x1_next, y0_next, y1_next;
    logic                       empty;
    logic [KW-1:0]              tr_a, tr_b;
    logic                       ge_a, ge_b;
    logic [AW-1:0]              ad_a_lo, ad_a_hi, ad_b_lo, ad_b_hi;
    logic [2*WB-1:0]            cat_a, cat_b;
    logic [WB-1:0]              win_a, win_b;
    logic                       hit_now;
    logic                       last_chunk;
    logic                       row_end;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign verdict   = verdict_reg;
    assign cfg_ready = 1'b1;

    // rectangle intersection
    always_comb
    begin
        xa_e = XW'(xa_reg);
        ya_e = XW'(ya_reg);
        xb_e = XW'(xb_reg);
        yb_e = XW'(yb_reg);
        x0_next = (xa_e > xb_e) ? xa_e : xb_e;
        y0_next = (ya_e > yb_e) ? ya_e : yb_e;
        x1_next = ((xa_e + $signed({1'b0, wa_reg})) < (xb_e + $signed({1'b0, wb_reg})))
                  ? (xa_e + $signed({1'b0, wa_reg})) : (xb_e + $signed({1'b0, wb_reg}));
        y1_next = ((ya_e + $signed({1'b0, ha_reg})) < (yb_e + $signed({1'b0, hb_reg})))
                  ? (ya_e + $signed({1'b0, ha_reg})) : (yb_e + $signed({1'b0, hb_reg}));
        empty = (x0_next >= x1_next) || (y0_next >= y1_next);
    end

    // restoring divider step
    always_comb
    begin
        tr_a = {ra_reg[KW-2:0], qa_reg[CW-1]};
        tr_b = {rb_reg[KW-2:0], qb_reg[CW-1]};
        ge_a = (tr_a >= da_reg);
        ge_b = (tr_b >= db_reg);
    end

    always_comb
    begin
        ad_a_lo = spc_pkg::word_index(px_a_reg, py_a_reg, 0);
        ad_a_hi = spc_pkg::word_index(px_a_reg, py_a_reg, 1);
        ad_b_lo = spc_pkg::word_index(px_b_reg, py_b_reg, 0);
        ad_b_hi = spc_pkg::word_index(px_b_reg, py_b_reg, 1);
        cat_a   = {rd_a_hi_reg, rd_a_lo_reg};
        cat_b   = {rd_b_hi_reg, rd_b_lo_reg};
        win_a   = cat_a[sh_a_reg +: WB];
        win_b   = cat_b[sh_b_reg +: WB];
        hit_now = pipe_valid_reg && ((win_a & mk_a_reg & win_b & mk_b_reg) != '0);
        row_end    = (int'(col_left_reg) <= WB);
        last_chunk = row_end && (rows_left_reg == SW'(1));
    end

    // mask stores: one write port, two read ports each
    always_ff @(posedge clk)
    begin
        if (accept && req_type == spc_pkg::REQ_LOAD && sheet_sel == spc_pkg::SHEET_A)
        begin
            mask_a_mem[word_addr] <= mask_word;
        end
        rd_a_lo_reg <= mask_a_mem[ad_a_lo];
        rd_a_hi_reg <= mask_a_mem[ad_a_hi];
    end

    always_ff @(posedge clk)
    begin
        if (accept && req_type == spc_pkg::REQ_LOAD && sheet_sel != spc_pkg::SHEET_A)
        begin
            mask_b_mem[word_addr] <= mask_word;
        end
        rd_b_lo_reg <= mask_b_mem[ad_b_lo];
        rd_b_hi_reg <= mask_b_mem[ad_b_hi];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_a_reg  <= SW'(16);
            ch_a_reg  <= SW'(16);
            cpr_a_reg <= KW'(8);
            cw_b_reg  <= SW'(16);
            ch_b_reg  <= SW'(16);
            cpr_b_reg <= KW'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                spc_pkg::CFG_CELL_WIDTH_A:    cw_a_reg  <= cfg_data[SW-1:0];
                spc_pkg::CFG_CELL_HEIGHT_A:   ch_a_reg  <= cfg_data[SW-1:0];
                spc_pkg::CFG_CELLS_PER_ROW_A: cpr_a_reg <= cfg_data;
                spc_pkg::CFG_CELL_WIDTH_B:    cw_b_reg  <= cfg_data[SW-1:0];
                spc_pkg::CFG_CELL_HEIGHT_B:   ch_b_reg  <= cfg_data[SW-1:0];
                spc_pkg::CFG_CELLS_PER_ROW_B: cpr_b_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            done_reg       <= 1'b0;
            verdict_reg    <= spc_pkg::VERDICT_DISJOINT;
            div_cnt_reg    <= '0;
            pipe_valid_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            done_reg       <= 1'b0;
            pipe_valid_reg <= (state_reg == S_SCAN);
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && req_type == spc_pkg::REQ_QUERY)
                    begin
                        state_reg <= S_RECT;
                    end
                end
                S_RECT:
                begin
                    div_cnt_reg <= '0;
                    if (empty)
                    begin
                        done_reg    <= 1'b1;
                        verdict_reg <= spc_pkg::VERDICT_DISJOINT;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'(CW - 1))
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    hit_reg   <= 1'b0;
                    state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    hit_reg <= hit_reg | hit_now;
                    if (last_chunk)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    done_reg    <= 1'b1;
                    verdict_reg <= (hit_reg || hit_now) ? spc_pkg::VERDICT_HIT
                                                        : spc_pkg::VERDICT_CLEAR;
                    state_reg   <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        sh_a_reg <= px_a_reg[4:0];
        sh_b_reg <= px_b_reg[4:0];
        mk_a_reg <= spc_pkg::chunk_mask(px_a_reg, py_a_reg, col_left_reg);
        mk_b_reg <= spc_pkg::chunk_mask(px_b_reg, py_b_reg, col_left_reg);
        case (state_reg)
            S_IDLE:
            begin
                xa_reg <= pos_x_a;
                ya_reg <= pos_y_a;
                xb_reg <= pos_x_b;
                yb_reg <= pos_y_b;
                wa_reg <= spc_pkg::clamp_size(cw_a_reg);
                ha_reg <= spc_pkg::clamp_size(ch_a_reg);
                wb_reg <= spc_pkg::clamp_size(cw_b_reg);
                hb_reg <= spc_pkg::clamp_size(ch_b_reg);
                da_reg <= spc_pkg::eff_cpr(cpr_a_reg);
                db_reg <= spc_pkg::eff_cpr(cpr_b_reg);
                qa_reg <= cell_a;
                qb_reg <= cell_b;
            end
            S_RECT:
            begin
                x0_reg     <= x0_next;
                y0_reg     <= y0_next;
                span_w_reg <= SW'(x1_next - x0_next);
                span_h_reg <= SW'(y1_next - y0_next);
                ra_reg     <= '0;
                rb_reg     <= '0;
            end
            S_DIV:
            begin
                ra_reg <= ge_a ? (tr_a - da_reg) : tr_a;
                rb_reg <= ge_b ? (tr_b - db_reg) : tr_b;
                qa_reg <= {qa_reg[CW-2:0], ge_a};
                qb_reg <= {qb_reg[CW-2:0], ge_b};
            end
            S_MUL:
            begin
                ox_a_reg <= spc_pkg::coord_t'(ra_reg) * spc_pkg::coord_t'(wa_reg)
                            - spc_pkg::coord_t'(xa_reg);
                oy_a_reg <= spc_pkg::coord_t'(qa_reg) * spc_pkg::coord_t'(ha_reg)
                            - spc_pkg::coord_t'(ya_reg);
                ox_b_reg <= spc_pkg::coord_t'(rb_reg) * spc_pkg::coord_t'(wb_reg)
                            - spc_pkg::coord_t'(xb_reg);
                oy_b_reg <= spc_pkg::coord_t'(qb_reg) * spc_pkg::coord_t'(hb_reg)
                            - spc_pkg::coord_t'(yb_reg);
            end
            S_SETUP:
            begin
                row_px_a_reg  <= ox_a_reg + spc_pkg::coord_t'(x0_reg);
                row_px_b_reg  <= ox_b_reg + spc_pkg::coord_t'(x0_reg);
                px_a_reg      <= ox_a_reg + spc_pkg::coord_t'(x0_reg);
                px_b_reg      <= ox_b_reg + spc_pkg::coord_t'(x0_reg);
                py_a_reg      <= oy_a_reg + spc_pkg::coord_t'(y0_reg);
                py_b_reg      <= oy_b_reg + spc_pkg::coord_t'(y0_reg);
                col_left_reg  <= span_w_reg;
                rows_left_reg <= span_h_reg;
            end
            S_SCAN:
            begin
                if (!row_end)
                begin
                    px_a_reg     <= px_a_reg + spc_pkg::coord_t'(WB);
                    px_b_reg     <= px_b_reg + spc_pkg::coord_t'(WB);
                    col_left_reg <= col_left_reg - SW'(WB);
                end
                else
                begin
                    px_a_reg      <= row_px_a_reg;
                    px_b_reg      <= row_px_b_reg;
                    py_a_reg      <= py_a_reg + spc_pkg::coord_t'(1);
                    py_b_reg      <= py_b_reg + spc_pkg::coord_t'(1);
                    col_left_reg  <= span_w_reg;
                    rows_left_reg <= rows_left_reg - SW'(1);
                end
            end
            default: ;
        endcase
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a query is in progress");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (verdict == spc_pkg::VERDICT_DISJOINT || verdict == spc_pkg::VERDICT_CLEAR
                  || verdict == spc_pkg::VERDICT_HIT))
        else $error("illegal verdict code");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (col_left_reg != '0 && rows_left_reg != '0))
        else $error("scan running over an empty overlap");

endmodule
